// File: hdl/bra_pkg.sv
package bra_pkg;

   localparam int MAX_ROWS  = 1024;
   localparam int WORD_BITS = 64;
   localparam int NUM_WORDS = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WIDX_W    = $clog2(NUM_WORDS);
   localparam int CNT_W     = ROW_W + 1;
   localparam int LEVEL_W   = 8;
   localparam int OP_W      = 3;
   localparam int MAP_W     = 2 * WORD_BITS;

   localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE       = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_VALID  = 3'd3;
   localparam logic [OP_W-1:0] OP_SET_LOCKED = 3'd4;
   localparam logic [OP_W-1:0] OP_SET_LEVEL  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [ROW_W-1:0]   row_index;
      logic               flag_value;
      logic [LEVEL_W-1:0] level_value;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   alloc_row;
      logic               alloc_full;
      logic               row_in_range;
      logic               row_valid;
      logic               row_locked;
      logic [LEVEL_W-1:0] row_level;
      logic [CNT_W-1:0]   live_rows;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REREAD,
      ST_EXEC
   } state_type;

   // lowest set bit of a map word
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] bits);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// File: hdl/bra_ram.sv
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/bra_ctrl.sv
module bra_ctrl (
   input  logic                             clock,
   input  logic                             clear,
   input  logic [bra_pkg::CNT_W-1:0]        rc,
   input  logic                             start,
   input  bra_pkg::req_type                 req,
   output logic                             busy,
   output logic                             rsp_valid,
   output bra_pkg::rsp_type                 rsp,
   output logic                             map_we,
   output logic [bra_pkg::WIDX_W-1:0]       map_waddr,
   output logic [bra_pkg::MAP_W-1:0]        map_wdata,
   output logic [bra_pkg::WIDX_W-1:0]       map_raddr,
   input  logic [bra_pkg::MAP_W-1:0]        map_rdata,
   output logic                             lvl_we,
   output logic [bra_pkg::ROW_W-1:0]        lvl_waddr,
   output logic [bra_pkg::LEVEL_W-1:0]      lvl_wdata,
   output logic [bra_pkg::ROW_W-1:0]        lvl_raddr,
   input  logic [bra_pkg::LEVEL_W-1:0]      lvl_rdata
);

   localparam int WB = bra_pkg::WORD_BITS;

   bra_pkg::state_type               state_ff, state_in;
   logic [bra_pkg::OP_W-1:0]         op_ff, op_in;
   logic [bra_pkg::ROW_W-1:0]        row_ff, row_in;
   logic                             flag_ff, flag_in;
   logic [bra_pkg::LEVEL_W-1:0]      level_ff, level_in;
   logic [bra_pkg::WIDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [bra_pkg::WIDX_W:0]         cnt_ff, cnt_in;
   logic [bra_pkg::CNT_W-1:0]        live_ff, live_in;
   logic [bra_pkg::WIDX_W-1:0]       cursor_ff, cursor_in;
   logic [bra_pkg::ROW_W-1:0]        clr_ff, clr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bra_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [bra_pkg::CNT_W:0]          words_sum;
   logic [bra_pkg::WIDX_W:0]         words;
   logic [bra_pkg::WIDX_W:0]         idx_inc;
   logic [bra_pkg::WIDX_W-1:0]       next_idx;
   logic [WB-1:0]                    vw, lw;
   logic [WB-1:0]                    tail_mask;
   logic [WB-1:0]                    free_bits;
   logic                             found;
   logic                             scan_done;
   logic [bra_pkg::BIT_W-1:0]        hit_bit;
   logic [bra_pkg::BIT_W-1:0]        tail_bits;
   logic                             in_range;
   logic [bra_pkg::BIT_W-1:0]        bsel;
   logic [bra_pkg::WIDX_W-1:0]       row_word;

   // scan helpers
   always_comb begin
      words_sum = {1'b0, rc} + (bra_pkg::CNT_W + 1)'(WB - 1);
      words     = words_sum[bra_pkg::BIT_W +: bra_pkg::WIDX_W + 1];
      idx_inc   = {1'b0, chk_idx_ff} + (bra_pkg::WIDX_W + 1)'(1);
      next_idx  = (idx_inc == words) ? '0 : idx_inc[bra_pkg::WIDX_W-1:0];
      vw        = map_rdata[WB-1:0];
      lw        = map_rdata[bra_pkg::MAP_W-1:WB];
      tail_bits = rc[bra_pkg::BIT_W-1:0];
      for (int i = 0; i < WB; i++) begin
         tail_mask[i] = (tail_bits == '0) || (bra_pkg::BIT_W'(i) < tail_bits);
      end
      // the last word only holds rows below the row count
      free_bits = ~vw;
      if (idx_inc == words) begin
         free_bits = free_bits & tail_mask;
      end
      found     = (free_bits != '0);
      hit_bit   = bra_pkg::first_set(free_bits);
      scan_done = ((cnt_ff + (bra_pkg::WIDX_W + 1)'(1)) == words);
      row_word  = row_ff[bra_pkg::ROW_W-1 -: bra_pkg::WIDX_W];
      bsel      = row_ff[bra_pkg::BIT_W-1:0];
      in_range  = ({1'b0, row_ff} < rc);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bra_pkg::ST_CLEAR: begin
            if (clr_ff == bra_pkg::ROW_W'(bra_pkg::MAX_ROWS - 1)) begin
               state_in = bra_pkg::ST_IDLE;
            end
         end
         bra_pkg::ST_IDLE: begin
            if (start) begin
               if (req.operation == bra_pkg::OP_ALLOC && rc != '0) begin
                  state_in = bra_pkg::ST_SCAN;
               end else begin
                  state_in = bra_pkg::ST_EXEC;
               end
            end
         end
         bra_pkg::ST_SCAN: begin
            if (found) begin
               state_in = bra_pkg::ST_IDLE;
            end else if (scan_done) begin
               state_in = bra_pkg::ST_REREAD;
            end
         end
         bra_pkg::ST_REREAD: state_in = bra_pkg::ST_EXEC;
         bra_pkg::ST_EXEC:   state_in = bra_pkg::ST_IDLE;
         default:            state_in = bra_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      logic [WB-1:0]               vw_n;
      logic [WB-1:0]               lw_n;
      logic [WB-1:0]               m;
      logic                        was;
      logic [bra_pkg::LEVEL_W-1:0] lvl_n;

      op_in        = op_ff;
      row_in       = row_ff;
      flag_in      = flag_ff;
      level_in     = level_ff;
      chk_idx_in   = chk_idx_ff;
      cnt_in       = cnt_ff;
      live_in      = live_ff;
      cursor_in    = cursor_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      map_we    = 1'b0;
      map_waddr = row_word;
      map_wdata = map_rdata;
      map_raddr = row_word;
      lvl_we    = 1'b0;
      lvl_waddr = row_ff;
      lvl_wdata = '0;
      lvl_raddr = row_ff;

      m     = WB'(1) << bsel;
      was   = vw[bsel];
      vw_n  = vw;
      lw_n  = lw;
      lvl_n = lvl_rdata;

      case (state_ff)
         bra_pkg::ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff[bra_pkg::WIDX_W-1:0];
            map_wdata = '0;
            lvl_we    = 1'b1;
            lvl_waddr = clr_ff;
            lvl_wdata = '0;
            clr_in    = clr_ff + bra_pkg::ROW_W'(1);
         end
         bra_pkg::ST_IDLE: begin
            // the read is issued on the accepting edge
            lvl_raddr = req.row_index;
            if (req.operation == bra_pkg::OP_ALLOC) begin
               map_raddr = cursor_ff;
            end else begin
               map_raddr = req.row_index[bra_pkg::ROW_W-1 -: bra_pkg::WIDX_W];
            end
            if (start) begin
               op_in      = req.operation;
               row_in     = req.row_index;
               flag_in    = req.flag_value;
               level_in   = req.level_value;
               chk_idx_in = cursor_ff;
               cnt_in     = '0;
            end
         end
         bra_pkg::ST_SCAN: begin
            map_raddr = next_idx;
            if (found) begin
               map_we    = 1'b1;
               map_waddr = chk_idx_ff;
               map_wdata = {lw, vw | (WB'(1) << hit_bit)};
               lvl_we    = 1'b1;
               lvl_waddr = {chk_idx_ff, hit_bit};
               lvl_wdata = '0;
               live_in   = live_ff + bra_pkg::CNT_W'(1);
               cursor_in = chk_idx_ff;
               rsp_valid_in        = 1'b1;
               rsp_in.alloc_row    = {chk_idx_ff, hit_bit};
               rsp_in.alloc_full   = 1'b0;
               rsp_in.row_in_range = 1'b1;
               rsp_in.row_valid    = 1'b1;
               rsp_in.row_locked   = lw[hit_bit];
               rsp_in.row_level    = '0;
               rsp_in.live_rows    = live_ff + bra_pkg::CNT_W'(1);
            end else begin
               chk_idx_in = next_idx;
               cnt_in     = cnt_ff + (bra_pkg::WIDX_W + 1)'(1);
            end
         end
         bra_pkg::ST_REREAD: begin
            map_raddr = row_word;
            lvl_raddr = row_ff;
         end
         bra_pkg::ST_EXEC: begin
            // an alloc only gets here when it failed, and then acts as query
            if (in_range) begin
               case (op_ff)
                  bra_pkg::OP_FREE: begin
                     vw_n   = vw & ~m;
                     lw_n   = lw & ~m;
                     map_we = 1'b1;
                     if (was) begin
                        live_in = live_ff - bra_pkg::CNT_W'(1);
                     end
                     if (row_word < cursor_ff) begin
                        cursor_in = row_word;
                     end
                  end
                  bra_pkg::OP_SET_VALID: begin
                     map_we = 1'b1;
                     if (flag_ff && !was) begin
                        vw_n    = vw | m;
                        live_in = live_ff + bra_pkg::CNT_W'(1);
                     end else if (!flag_ff && was) begin
                        vw_n    = vw & ~m;
                        live_in = live_ff - bra_pkg::CNT_W'(1);
                     end
                  end
                  bra_pkg::OP_SET_LOCKED: begin
                     map_we = 1'b1;
                     lw_n   = flag_ff ? (lw | m) : (lw & ~m);
                  end
                  bra_pkg::OP_SET_LEVEL: begin
                     lvl_we    = 1'b1;
                     lvl_wdata = level_ff;
                     lvl_n     = level_ff;
                  end
                  default: begin
                  end
               endcase
            end
            map_wdata           = {lw_n, vw_n};
            rsp_valid_in        = 1'b1;
            rsp_in.alloc_row    = '0;
            rsp_in.alloc_full   = (op_ff == bra_pkg::OP_ALLOC);
            rsp_in.row_in_range = in_range;
            rsp_in.row_valid    = in_range & vw_n[bsel];
            rsp_in.row_locked   = in_range & lw_n[bsel];
            rsp_in.row_level    = in_range ? lvl_n : '0;
            rsp_in.live_rows    = live_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         state_ff     <= bra_pkg::ST_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      row_ff     <= row_in;
      flag_ff    <= flag_in;
      level_ff   <= level_in;
      chk_idx_ff <= chk_idx_in;
      cnt_ff     <= cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != bra_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hdl/bitmap_row_slot_allocator_core.sv
// channel   ports                          handshake
// request   start, busy, req_data          beat taken when start && !busy
// response  rsp_valid, rsp_data            one-cycle strobe, always taken
// config    csr_valid, csr_ready, csr_data beat taken when csr_valid && csr_ready
//
// query, free and set operations hold busy high in their execute state after the
// accept cycle; the result is strobed on the cycle busy drops. alloc reads
// one bitmap word per cycle from the cursor until it finds a free row or, when the
// pool is full, has read every word and answers as a query. reset and every row_count write
// start a clearing pass over the level memory (and the bitmaps)
// with busy high. the response side has no stall; results are registered and
// shown once.
module bitmap_row_slot_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bra_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output bra_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bra_pkg::CNT_W-1:0]     csr_data
);

   logic [bra_pkg::CNT_W-1:0]   row_count_ff, row_count_in;
   logic [bra_pkg::CNT_W-1:0]   rc_eff;
   logic                        csr_write;
   logic                        clear;

   logic                        map_we;
   logic [bra_pkg::WIDX_W-1:0]  map_waddr;
   logic [bra_pkg::MAP_W-1:0]   map_wdata;
   logic [bra_pkg::WIDX_W-1:0]  map_raddr;
   logic [bra_pkg::MAP_W-1:0]   map_rdata;
   logic                        lvl_we;
   logic [bra_pkg::ROW_W-1:0]   lvl_waddr;
   logic [bra_pkg::LEVEL_W-1:0] lvl_wdata;
   logic [bra_pkg::ROW_W-1:0]   lvl_raddr;
   logic [bra_pkg::LEVEL_W-1:0] lvl_rdata;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign clear     = reset | csr_write;

   always_comb begin
      row_count_in = row_count_ff;
      if (csr_write) begin
         row_count_in = csr_data;
      end
      // counts above the pool size act as the pool size
      if (row_count_ff > bra_pkg::CNT_W'(bra_pkg::MAX_ROWS)) begin
         rc_eff = bra_pkg::CNT_W'(bra_pkg::MAX_ROWS);
      end else begin
         rc_eff = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= bra_pkg::CNT_W'(bra_pkg::MAX_ROWS);
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   bra_ctrl u_ctrl (
      .clock     (clock),
      .clear     (clear),
      .rc        (rc_eff),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .map_we    (map_we),
      .map_waddr (map_waddr),
      .map_wdata (map_wdata),
      .map_raddr (map_raddr),
      .map_rdata (map_rdata),
      .lvl_we    (lvl_we),
      .lvl_waddr (lvl_waddr),
      .lvl_wdata (lvl_wdata),
      .lvl_raddr (lvl_raddr),
      .lvl_rdata (lvl_rdata)
   );

   // locked word in the upper half, valid word in the lower half
   bra_ram #(
      .WIDTH (bra_pkg::MAP_W),
      .DEPTH (bra_pkg::NUM_WORDS)
   ) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   bra_ram #(
      .WIDTH (bra_pkg::LEVEL_W),
      .DEPTH (bra_pkg::MAX_ROWS)
   ) u_level_ram (
      .clock (clock),
      .we    (lvl_we),
      .waddr (lvl_waddr),
      .wdata (lvl_wdata),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

endmodule
